// ----- sv/rzmn_pkg.sv -----
`default_nettype none
package rzmn_pkg;
    localparam int MAX_COLS = 64;
    localparam int AW = 6;
    localparam logic [1:0] MODE_SD = 2'd0;
    localparam logic [1:0] MODE_LEN_CONST = 2'd1;
    localparam logic CFG_MODE = 1'd0;
    localparam logic CFG_COLS = 1'd1;
endpackage
`default_nettype wire

// ----- sv/row_zero_mean_normalizer_top.sv -----
// Row zero-mean normalizer.
// Input channel: one signed Q8.8 sample per word (i_valid/o_ready).
// Output channel: one signed Q5.12 normalized value per word, with row_end on
// the last word of a row and const_row on rows of near-zero spread.
// Config channel (i_cfg_valid/o_cfg_ready, index, data): 0 = mode, 1 = col_count;
// write only while idle.
// Samples load into a 64-entry row memory at one word per cycle. When the
// row holds n samples the block stops taking input, then:
//   statistics pass (memory read, sum and sum of squares),
//   spread setup,
//   emit pass: per element a memory read, deviation and square,
//   a 32-step serial quotient of dev^2*2^26 by the spread, a 16-step serial
//   square root and a rounding step.
// Input reopens in the cycle after the last word of the row is valid.
// Throughput is set by the serial divider and root in the emit pass.
// A stalled receiver holds the output register; the next word waits.
// Reset clears mode to 0, col_count to 64 and empties the row.
`default_nettype none
module row_zero_mean_normalizer_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_sample,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [17:0]      o_norm_value,
    output logic                    o_row_end,
    output logic                    o_const_row,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data
);
    import rzmn_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0, S_STAT = 4'd1, S_U = 4'd2, S_U2 = 4'd3,
        S_SQ = 4'd4, S_RD = 4'd5, S_D = 4'd6, S_DIV = 4'd7, S_RND = 4'd8,
        S_OUT = 4'd9, S_MUL = 4'd10;

    logic signed [15:0] r_mem [MAX_COLS];
    logic signed [15:0] r_rdata;
    logic [AW-1:0] r_raddr;

    logic [3:0] r_st;
    logic [1:0] r_mode;
    logic [6:0] r_cols;
    logic [6:0] r_fill;
    logic [6:0] r_n;
    logic [6:0] r_cnt;
    logic       r_rdv;
    logic signed [21:0] r_s;
    logic [37:0] r_q;
    logic [45:0] r_u;
    logic [43:0] r_ss;
    logic [52:0] r_v;
    logic        r_const;
    // per element: quotient dev^2*2^26/v, then its square root
    logic [22:0] r_dmag;
    logic        r_neg;
    logic [31:0] r_num;
    logic [52:0] r_prem;
    logic [31:0] r_quo;
    logic [4:0]  r_qi;
    logic [17:0] r_rem;
    logic [15:0] r_root;
    logic signed [17:0] r_out;
    logic        r_oval;
    logic        r_last;

    logic [6:0] w_n;
    always_comb begin
        if (r_cols < 7'd2) w_n = 7'd2;
        else if (r_cols > 7'd64) w_n = 7'd64;
        else w_n = r_cols;
    end

    assign o_ready     = (r_st == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_valid      = r_oval;
    assign o_norm_value = r_out;
    assign o_row_end    = r_last;

    logic r_constq;
    assign o_const_row = r_constq;

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && r_fill < 7'(MAX_COLS)) r_mem[r_fill[AW-1:0]] <= i_sample;
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_mode <= 2'd0; r_cols <= 7'd64; r_fill <= '0;
            r_oval <= 1'b0; r_rdv <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_COLS) r_cols <= i_cfg_data;
                else r_mode <= i_cfg_data[1:0];
            end
            if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_st)
                S_LOAD: if (i_valid) begin
                    if (r_fill + 7'd1 >= w_n) begin
                        r_n <= w_n; r_st <= S_STAT; r_cnt <= '0; r_raddr <= '0;
                        r_s <= '0; r_q <= '0; r_rdv <= 1'b0;
                    end else r_fill <= r_fill + 7'd1;
                end
                S_STAT: begin
                    r_rdv <= (r_cnt < r_n);
                    if (r_cnt < r_n) begin
                        r_raddr <= AW'(r_cnt + 7'd1);
                        r_cnt <= r_cnt + 7'd1;
                    end
                    if (r_rdv) begin
                        r_s <= r_s + 22'(r_rdata);
                        r_q <= r_q + 38'($unsigned(32'(r_rdata) * 32'(r_rdata)));
                    end
                    if (!r_rdv && r_cnt == r_n) r_st <= S_U;
                end
                S_U: begin
                    r_u <= 46'(r_n) * 46'(r_q);
                    r_ss <= 44'($unsigned(44'(r_s) * 44'(r_s)));
                    r_st <= S_U2;
                end
                S_U2: begin
                    logic [45:0] uu;
                    uu = (r_u > 46'(r_ss)) ? r_u - 46'(r_ss) : '0;
                    r_u <= uu;
                    r_const <= uu < 46'(r_n);
                    if (uu < 46'(r_n)) r_v <= 53'(r_n);
                    else if (r_mode == MODE_SD) r_v <= 53'(uu);
                    else r_v <= 53'(uu) * 53'(r_n);
                    r_cnt <= '0; r_raddr <= '0;
                    r_st <= S_RD;
                end
                S_RD: if (!r_oval) r_st <= S_D;
                S_D: begin
                    logic signed [23:0] d;
                    d = 24'(signed'({1'b0, r_n})) * 24'(r_rdata) - 24'(r_s);
                    r_neg <= !r_const && d[23];
                    if (r_const) r_dmag <= 23'd1;
                    else r_dmag <= d[23] ? 23'(-d) : 23'(d);
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    logic [45:0] sq;
                    sq = r_dmag * r_dmag;
                    r_prem <= 53'(sq[45:6]);
                    r_num <= {sq[5:0], 26'd0};
                    r_quo <= '0; r_qi <= '0;
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    logic [53:0] t;
                    t = {r_prem, r_num[31]};
                    r_num <= r_num << 1;
                    if (t >= {1'b0, r_v}) begin
                        r_prem <= 53'(t - {1'b0, r_v}); r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_prem <= 53'(t); r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_qi <= r_qi + 5'd1;
                    if (r_qi == 5'd31) begin
                        r_rem <= '0; r_root <= '0; r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    logic [19:0] rs;
                    logic [19:0] tr;
                    rs = {r_rem, r_quo[31:30]};
                    tr = {2'd0, r_root, 2'b01};
                    r_quo <= r_quo << 2;
                    if (rs >= tr) begin
                        r_rem <= 18'(rs - tr); r_root <= {r_root[14:0], 1'b1};
                    end else begin
                        r_rem <= 18'(rs); r_root <= {r_root[14:0], 1'b0};
                    end
                    r_qi <= r_qi + 5'd1;
                    if (r_qi == 5'd15) r_st <= S_RND;
                end
                S_RND: begin
                    logic [16:0] m;
                    m = (17'(r_root) + 17'd1) >> 1;
                    if (r_const && r_mode != MODE_LEN_CONST) m = '0;
                    r_out <= r_neg ? -$signed(18'(m)) : $signed(18'(m));
                    r_constq <= r_const;
                    r_last <= (r_cnt + 7'd1 == r_n);
                    r_oval <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (r_cnt + 7'd1 == r_n) begin
                        r_st <= S_LOAD; r_fill <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                        r_raddr <= AW'(r_cnt + 7'd1);
                        r_st <= S_RD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- verif/rzmn_checker.sv -----
module rzmn_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic signed [15:0] i_sample,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [17:0] i_norm_value,
    input  wire logic               i_row_end,
    input  wire logic               i_const_row,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    import rzmn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [17:0] norm_value;
        logic               row_end;
        logic               const_row;
    } t_norm_word;

    t_norm_word         norm_expected[$];
    logic [1:0]         mode_q;
    logic [6:0]         cols_q;
    logic signed [15:0] row_held[MAX_COLS];
    int                 held_count;

    // largest m <= cap with m == 0 or (2m-1)^2 * v <= mag^2 * 2^26
    function automatic int unsigned scaled_ratio(longint unsigned mag, logic [127:0] v,
                                                 int unsigned cap);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] t;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = {64'd0, mag};
        rhs = (rhs * rhs) << 26;
        lo = 0;
        hi = cap;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 128'(2 * mid - 1);
            lhs = t * t * v;
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    task automatic normalize_row(int n);
        longint       s;
        longint       q;
        longint       u;
        longint       d;
        logic [127:0] vden;
        bit           is_const;
        int           val;
        t_norm_word   w;
        s = 0;
        q = 0;
        for (int j = 0; j < n; j++) begin
            s += row_held[j];
            q += longint'(row_held[j]) * row_held[j];
        end
        u = n * q - s * s;
        if (u < 0) u = 0;
        is_const = (u < n);
        for (int j = 0; j < n; j++) begin
            if (is_const) begin
                val = (mode_q == MODE_LEN_CONST) ? int'(scaled_ratio(1, n, 131071)) : 0;
            end else begin
                d = n * longint'(row_held[j]) - s;
                vden = (mode_q == MODE_SD) ? 128'(u) : 128'(u) * n;
                if (d < 0) begin
                    val = -int'(scaled_ratio(-d, vden, 131072));
                end else begin
                    val = int'(scaled_ratio(d, vden, 131071));
                end
            end
            w.norm_value = val[17:0];
            w.row_end = (j + 1 == n);
            w.const_row = is_const;
            norm_expected.push_back(w);
        end
    endtask

    assign o_pending = norm_expected.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        int         n;
        t_norm_word e;
        if (!i_rst_n) begin
            mode_q <= MODE_SD;
            cols_q <= 7'd64;
            held_count = 0;
            norm_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_COLS) begin
                    cols_q <= i_cfg_data;
                end else begin
                    mode_q <= i_cfg_data[1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                n = (cols_q < 2) ? 2 : (cols_q > MAX_COLS) ? MAX_COLS : int'(cols_q);
                if (held_count < MAX_COLS) row_held[held_count] = i_sample;
                if (held_count + 1 < n) begin
                    held_count++;
                end else begin
                    normalize_row(n);
                    held_count = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (norm_expected.size() == 0) begin
                    $display("%0t: unexpected word norm=%0d end=%0b const=%0b", $time,
                             i_norm_value, i_row_end, i_const_row);
                    o_fail_count++;
                end else begin
                    e = norm_expected.pop_front();
                    if (e.norm_value !== i_norm_value || e.row_end !== i_row_end
                            || e.const_row !== i_const_row) begin
                        $display("%0t: mismatch exp norm=%0d end=%0b const=%0b",
                                 $time, e.norm_value, e.row_end, e.const_row);
                        $display("%0t:          got norm=%0d end=%0b const=%0b",
                                 $time, i_norm_value, i_row_end, i_const_row);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import rzmn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_LEN_ZERO = 2'd2;
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_sample;
    logic               o_valid;
    logic               i_ready;
    logic signed [17:0] o_norm_value;
    logic               o_row_end;
    logic               o_const_row;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [6:0]         i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 words_sent;
    bit                 hold_req;

    row_zero_mean_normalizer_top uut (.*);

    rzmn_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_sample(i_sample),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_norm_value(o_norm_value),
        .i_row_end(o_row_end), .i_const_row(o_const_row),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: ready pattern changes every window; long hold on request
    initial begin
        int win_mode;
        i_ready = 1'b0;
        forever begin
            win_mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 64)) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_ready = 1'b0;
                    repeat (3000) @(negedge i_clk);
                end
                case (win_mode)
                    0: i_ready = 1'b1;
                    1: i_ready = $urandom_range(0, 1);
                    2: i_ready = ($urandom_range(0, 3) == 0);
                    default: i_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic put_word(logic signed [15:0] v);
        i_sample = v;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        words_sent++;
        if ($urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [6:0] data);
        drain();
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_mode(logic [1:0] m);
        cfg_write(1'(CFG_MODE), {5'($urandom_range(0, 31)), m});
    endtask

    task automatic put_pair(logic signed [15:0] a, logic signed [15:0] b);
        put_word(a);
        put_word(b);
    endtask

    task automatic send_row(int n);
        int                 kind;
        logic signed [15:0] base;
        int                 odd;
        kind = $urandom_range(0, 5);
        base = 16'($urandom);
        odd = $urandom_range(0, n - 1);
        for (int j = 0; j < n; j++) begin
            case (kind)
                0, 1: put_word(16'($urandom));
                2: put_word(base + 16'($urandom_range(0, 40)) - 16'sd20);
                3: put_word(base);
                4: put_word((j == odd) ? base ^ 16'sd1 : base);
                default: put_word($urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                                       : 16'sh8000 + 16'($urandom_range(0, 3)));
            endcase
        end
    endtask

    initial begin
        int raw_cols;
        int n;
        int phase;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_req = 1'b0;
        words_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cfg_write(CFG_COLS, 7'd2);
        put_pair(16'sh8000, 16'sh7fff);
        put_pair(16'sd100, 16'sd100);
        put_pair(16'sd0, 16'sd1);
        set_mode(MODE_LEN_CONST);
        put_pair(16'sd7, 16'sd7);
        put_pair(16'sh8000, 16'sh8001);
        put_pair(16'sd3, -16'sd5);
        set_mode(MODE_LEN_ZERO);
        put_pair(16'sd9, 16'sd9);
        put_pair(16'sd1000, -16'sd1000);
        set_mode(MODE_ALIAS);
        cfg_write(CFG_COLS, 7'd0);
        put_pair(16'sd12, 16'sd12);
        put_pair(16'sh7fff, 16'sh8000);
        set_mode(MODE_SD);
        cfg_write(CFG_COLS, 7'd1);
        put_pair(16'sd5, -16'sd5);
        // shrink the row length while a row is partly loaded
        cfg_write(CFG_COLS, 7'd8);
        repeat (5) put_word(16'($urandom));
        cfg_write(CFG_COLS, 7'd3);
        put_word(16'($urandom));

        phase = 0;
        while (words_sent < 200) begin
            set_mode(phase == 1 ? MODE_LEN_CONST : 2'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: raw_cols = $urandom_range(2, 8);
                7: raw_cols = $urandom_range(9, 64);
                8: raw_cols = $urandom_range(0, 1);
                default: raw_cols = $urandom_range(65, 127);
            endcase
            if (phase == 0) raw_cols = 127;
            if (phase == 1) raw_cols = 64;
            if (phase == 2) raw_cols = 8;
            cfg_write(CFG_COLS, 7'(raw_cols));
            n = (raw_cols < 2) ? 2 : (raw_cols > MAX_COLS) ? MAX_COLS : raw_cols;
            if (phase == 2) hold_req = 1'b1;
            repeat ((n <= 8) ? $urandom_range(3, 6) : 1) send_row(n);
            phase++;
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
